### hw/rtl/rgb_strip_linear_fade_top_assert.svh
// Assertion macros for the RGB strip fade engine.
// Used by rgb_strip_linear_fade_top; expects clk and rst_n in scope.
`ifndef RGB_STRIP_LINEAR_FADE_TOP_ASSERT_SVH
`define RGB_STRIP_LINEAR_FADE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define RSF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rsf assertion failed");

// next-cycle implication
`define RSF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rsf assertion failed");

`else

`define RSF_ASSERT_NOW(lbl, ante, cons)
`define RSF_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### hw/rtl/rsf_pkg.sv
// Shared types and constants for the RGB strip fade engine.
// No dependencies; used by all rsf modules and the top level.
package rsf_pkg;

  // index 0 red, 1 green, 2 blue
  typedef logic [2:0][7:0] rgb_t;
  typedef logic [2:0][8:0] step_t;   // two's complement per channel

  typedef struct packed {
    rgb_t  cur;
    rgb_t  tgt;
    step_t step;
  } entry_t;

  typedef enum logic [1:0] {
    REQ_WCUR = 2'd0,
    REQ_WTGT = 2'd1,
    REQ_TICK = 2'd2,
    REQ_READ = 2'd3
  } req_t;

  localparam logic [1:0] CFG_PIXEL_COUNT = 2'd0;
  localparam logic [1:0] CFG_FADE_TICKS  = 2'd1;

  localparam logic [6:0] PIXEL_COUNT_RST = 7'd64;
  localparam logic [7:0] FADE_TICKS_RST  = 8'd32;

  // divider: 8-bit magnitude, two quotient bits per cycle
  localparam int DIV_W     = 8;
  localparam int DIV_RADIX = 2;
  localparam int DIV_ITER  = DIV_W / DIV_RADIX;

endpackage

### hw/rtl/rgb_strip_linear_fade_top.sv
// RGB strip linear fade engine, top level: request sequencer and datapath.
// Depends on rsf_pkg, rsf_store, rsf_div and rgb_strip_linear_fade_top_assert.svh.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  req_type, first_pixel, end_pixel, rgb
//   out_     output     out_valid/out_stall  red, green, blue, fading
//   cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_wdata
//
// After reset a clearing pass writes MAX_PIXELS entries, one per cycle, with in_stall high.
// One transaction at a time, set by the single state memory port. Write current visits each
// pixel written, tick each pixel in use while fading, write target each pixel in use (read,
// divider run, write back), and a read one pixel.
// in_stall is high from accept until the result is in the output register; a stalled
// output holds the sequencer in its final state.
module rgb_strip_linear_fade_top #(
  parameter int MAX_PIXELS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_req_type,
  input  logic [5:0] in_first_pixel,
  input  logic [6:0] in_end_pixel,
  input  logic [7:0] in_red_in,
  input  logic [7:0] in_green_in,
  input  logic [7:0] in_blue_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red_out,
  output logic [7:0] out_green_out,
  output logic [7:0] out_blue_out,
  output logic       out_fading,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int PW = ((AW > 7) ? AW : 7) + 1;

  typedef enum logic [5:0] {
    ST_CLR  = 6'b000001,
    ST_IDLE = 6'b000010,
    ST_RD   = 6'b000100,
    ST_EX   = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  state_t          state_r, state_nxt;
  logic [PW-1:0]   p_r, p_nxt, limit_r, limit_nxt, first_r, first_nxt, endc_r, endc_nxt;
  rsf_pkg::req_t   req_r, req_nxt;
  rsf_pkg::rgb_t   rgb_r, rgb_nxt, col_r, col_nxt;
  logic            fade_r, fade_nxt;
  logic [6:0]      pcount_r;
  logic [7:0]      ticks_r;
  logic            out_valid_r, out_valid_nxt, out_fade_r;
  rsf_pkg::rgb_t   out_col_r;

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcount_r <= rsf_pkg::PIXEL_COUNT_RST;
      ticks_r  <= rsf_pkg::FADE_TICKS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rsf_pkg::CFG_PIXEL_COUNT: pcount_r <= cfg_wdata[6:0];
        rsf_pkg::CFG_FADE_TICKS:  ticks_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- state memory ----------------
  logic            mem_we, mem_re;
  rsf_pkg::entry_t mem_wdata, rd;

  rsf_store #(.DEPTH(MAX_PIXELS), .AW(AW)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (p_r[AW-1:0]),
    .wdata (mem_wdata),
    .rdata (rd)
  );

  // ---------------- step recompute ----------------
  logic [7:0]    ticks_eff;
  logic          in_rng;
  rsf_pkg::rgb_t new_tgt;
  logic [2:0][7:0] mag, quot;
  logic [2:0]    neg, div_done;
  rsf_pkg::step_t step_new;
  logic          div_start, all_done;

  assign ticks_eff = (ticks_r == 8'd0) ? 8'd1 : ticks_r;
  assign in_rng    = (p_r >= first_r) && (p_r < endc_r);
  assign new_tgt   = in_rng ? rgb_r : rd.tgt;
  assign div_start = (state_r == ST_EX) && (req_r == rsf_pkg::REQ_WTGT);
  assign all_done  = &div_done;

  always_comb begin
    logic [9:0] diff;
    logic [8:0] qx;
    for (int c = 0; c < 3; c++) begin
      diff        = {2'b00, new_tgt[c]} - {2'b00, rd.cur[c]};
      neg[c]      = diff[9];
      mag[c]      = diff[9] ? 8'(-diff) : diff[7:0];
      qx          = {1'b0, quot[c]};
      step_new[c] = neg[c] ? (~qx + 9'd1) : qx;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_div
    rsf_div u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (div_start),
      .dividend (mag[c]),
      .divisor  (ticks_eff),
      .done     (div_done[c]),
      .quotient (quot[c])
    );
  end

  // ---------------- tick update ----------------
  rsf_pkg::entry_t ticked;
  logic [2:0]      moved;

  always_comb begin
    logic [9:0] delta, v;
    logic [7:0] ad;
    logic [8:0] as9, s;
    ticked = rd;
    for (int c = 0; c < 3; c++) begin
      s        = rd.step[c];
      delta    = {2'b00, rd.tgt[c]} - {2'b00, rd.cur[c]};
      ad       = delta[9] ? 8'(-delta) : delta[7:0];
      as9      = s[8] ? (~s + 9'd1) : s;   // -256 reads as 256 unsigned
      v        = {2'b00, rd.cur[c]} + {s[8], s};
      moved[c] = (s != 9'd0) && ({1'b0, ad} > as9);
      if (moved[c]) begin
        // stale step after a current write may overshoot: clamp
        if (v[9]) begin
          ticked.cur[c] = 8'd0;
        end else if (v[8]) begin
          ticked.cur[c] = 8'd255;
        end else begin
          ticked.cur[c] = v[7:0];
        end
      end else begin
        ticked.cur[c]  = rd.tgt[c];
        ticked.step[c] = 9'd0;
      end
    end
  end

  // ---------------- sequencer ----------------
  logic [PW-1:0] n_w, end_w, endc_w, first_w, p_inc;
  logic          more, out_free;

  assign n_w      = (PW'(pcount_r) < PW'(MAX_PIXELS)) ? PW'(pcount_r) : PW'(MAX_PIXELS);
  assign end_w    = PW'(in_end_pixel);
  assign endc_w   = (end_w > n_w) ? n_w : end_w;
  assign first_w  = PW'(in_first_pixel);
  assign p_inc    = p_r + PW'(1);
  assign more     = p_inc < limit_r;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    p_nxt     = p_r;
    limit_nxt = limit_r;
    first_nxt = first_r;
    endc_nxt  = endc_r;
    req_nxt   = req_r;
    rgb_nxt   = rgb_r;
    col_nxt   = col_r;
    fade_nxt  = fade_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wdata = rd;
    unique case (state_r)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        if (p_r == PW'(MAX_PIXELS - 1)) begin
          state_nxt = ST_IDLE;
          p_nxt     = '0;
        end else begin
          p_nxt = p_inc;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt   = rsf_pkg::req_t'(in_req_type);
          first_nxt = first_w;
          endc_nxt  = endc_w;
          rgb_nxt   = {in_blue_in, in_green_in, in_red_in};
          col_nxt   = '0;
          state_nxt = ST_FIN;
          unique case (rsf_pkg::req_t'(in_req_type))
            rsf_pkg::REQ_WCUR: begin
              p_nxt     = first_w;
              limit_nxt = endc_w;
              if (first_w < endc_w) state_nxt = ST_RD;
            end
            rsf_pkg::REQ_WTGT: begin
              p_nxt     = '0;
              limit_nxt = n_w;
              fade_nxt  = 1'b1;
              if (n_w != '0) state_nxt = ST_RD;
            end
            rsf_pkg::REQ_TICK: begin
              p_nxt     = '0;
              limit_nxt = n_w;
              if (fade_r) begin
                fade_nxt = 1'b0;
                if (n_w != '0) state_nxt = ST_RD;
              end
            end
            rsf_pkg::REQ_READ: begin
              p_nxt     = first_w;
              limit_nxt = n_w;
              if (first_w < n_w) state_nxt = ST_RD;
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        mem_re    = 1'b1;
        state_nxt = ST_EX;
      end
      ST_EX: begin
        unique case (req_r)
          rsf_pkg::REQ_WCUR: begin
            mem_we        = 1'b1;
            mem_wdata.cur = rgb_r;
            p_nxt         = p_inc;
            state_nxt     = more ? ST_RD : ST_FIN;
          end
          rsf_pkg::REQ_TICK: begin
            mem_we    = 1'b1;
            mem_wdata = ticked;
            if (|moved) fade_nxt = 1'b1;
            p_nxt     = p_inc;
            state_nxt = more ? ST_RD : ST_FIN;
          end
          rsf_pkg::REQ_WTGT: begin
            state_nxt = ST_DIV;
          end
          rsf_pkg::REQ_READ: begin
            col_nxt   = rd.cur;
            state_nxt = ST_FIN;
          end
          default: ;
        endcase
      end
      ST_DIV: begin
        if (all_done) begin
          mem_we         = 1'b1;
          mem_wdata.tgt  = new_tgt;
          mem_wdata.step = step_new;
          p_nxt          = p_inc;
          state_nxt      = more ? ST_RD : ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (state_r == ST_FIN && out_free) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      p_r         <= '0;
      fade_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      p_r         <= p_nxt;
      fade_r      <= fade_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    limit_r <= limit_nxt;
    first_r <= first_nxt;
    endc_r  <= endc_nxt;
    req_r   <= req_nxt;
    rgb_r   <= rgb_nxt;
    col_r   <= col_nxt;
    if (state_r == ST_FIN && out_free) begin
      out_col_r  <= col_r;
      out_fade_r <= fade_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = out_col_r[0];
  assign out_green_out = out_col_r[1];
  assign out_blue_out  = out_col_r[2];
  assign out_fading    = out_fade_r;

  // ---------------- assertions ----------------
`include "rgb_strip_linear_fade_top_assert.svh"

  `RSF_ASSERT_NOW(a_tgt_arms, (state_r == ST_FIN) && (req_r == rsf_pkg::REQ_WTGT), fade_r)
  `RSF_ASSERT_NOW(a_div_seq, div_done[0], state_r == ST_DIV)
  `RSF_ASSERT_NOW(a_zero_col, (state_r == ST_FIN) && (req_r != rsf_pkg::REQ_READ), col_r == '0)
  `RSF_ASSERT_NOW(a_rd_bound, state_r == ST_RD, p_r < limit_r)
  `RSF_ASSERT_NEXT(a_load_out, (state_r == ST_FIN) && out_free, out_valid_r)

endmodule

### hw/rtl/rsf_div.sv
// Iterative unsigned 8/8 divider, restoring, two quotient bits per cycle.
// Depends on rsf_pkg for the iteration count and radix.
module rsf_div (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [7:0] dividend,
  input  logic [7:0] divisor,
  output logic       done,
  output logic [7:0] quotient
);

  localparam int CW = (rsf_pkg::DIV_ITER > 1) ? $clog2(rsf_pkg::DIV_ITER) : 1;

  logic [7:0]    rem_r, quo_r, dsr_r;
  logic [7:0]    rem_nxt, quo_nxt;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;

  always_comb begin
    logic [8:0] trial;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int i = 0; i < rsf_pkg::DIV_RADIX; i++) begin
      trial   = {rem_nxt, quo_nxt[7]};
      quo_nxt = {quo_nxt[6:0], 1'b0};
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt    = 8'(trial - {1'b0, dsr_r});
        quo_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(rsf_pkg::DIV_ITER - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### hw/rtl/rsf_store.sv
// Per-pixel state memory: current colour, target colour and steps.
// Single port, registered read. Depends on rsf_pkg.
module rsf_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic                  re,
  input  logic [AW-1:0]         addr,
  input  rsf_pkg::entry_t       wdata,
  output rsf_pkg::entry_t       rdata
);

  rsf_pkg::entry_t mem [DEPTH];
  rsf_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule
